// ===== src/csba_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package csba_pkg;

    localparam int unsigned NUM_BUTTONS = 3;

    localparam logic [1:0] KEY_MODE = 2'd0;
    localparam logic [1:0] KEY_UP   = 2'd1;
    localparam logic [1:0] KEY_DOWN = 2'd2;

    localparam logic [3:0] MODE_NORMAL       = 4'd0;
    localparam logic [3:0] MODE_HOUR         = 4'd1;
    localparam logic [3:0] MODE_MINUTE       = 4'd2;
    localparam logic [3:0] MODE_SECOND       = 4'd3;
    localparam logic [3:0] MODE_DAY          = 4'd4;
    localparam logic [3:0] MODE_MONTH        = 4'd5;
    localparam logic [3:0] MODE_YEAR         = 4'd6;
    localparam logic [3:0] MODE_ALARM_ON     = 4'd7;
    localparam logic [3:0] MODE_ALARM_HOUR   = 4'd8;
    localparam logic [3:0] MODE_ALARM_MINUTE = 4'd9;
    localparam logic [3:0] MODE_LAST         = MODE_ALARM_MINUTE;

    localparam logic [5:0] HOUR_MAX   = 6'd23;
    localparam logic [5:0] MINUTE_MAX = 6'd59;
    localparam logic [5:0] DAY_MIN    = 6'd1;
    localparam logic [5:0] DAY_MAX    = 6'd31;
    localparam logic [5:0] MONTH_MIN  = 6'd1;
    localparam logic [5:0] MONTH_MAX  = 6'd12;
    localparam logic [5:0] ZERO_MIN   = 6'd0;

    localparam int unsigned APB_ADDR_W = 3;
    localparam logic REG_HOLD_DELAY      = 1'b0;
    localparam logic REG_REPEAT_INTERVAL = 1'b1;

    localparam logic [15:0] HOLD_DELAY_RESET      = 16'd600;
    localparam logic [15:0] REPEAT_INTERVAL_RESET = 16'd150;

    typedef struct packed {
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [15:0] year;
        logic        alarm_on;
        logic [4:0]  alarm_hour;
        logic [5:0]  alarm_minute;
    } fields_t;

    localparam fields_t FIELDS_RESET = '{
        hour: 5'd0, minute: 6'd0, second: 6'd0, day: 5'd1, month: 4'd1,
        year: 16'd2000, alarm_on: 1'b0, alarm_hour: 5'd0, alarm_minute: 6'd0
    };

    function automatic logic [5:0] wrap_up(logic [5:0] v, logic [5:0] lo, logic [5:0] hi);
        return (v >= hi || v < lo) ? lo : v + 6'd1;
    endfunction

    function automatic logic [5:0] wrap_down(logic [5:0] v, logic [5:0] lo, logic [5:0] hi);
        return (v <= lo || v > hi) ? hi : v - 6'd1;
    endfunction

    function automatic logic [5:0] wrap_step(logic [5:0] v, logic [5:0] lo, logic [5:0] hi,
                                             logic up);
        return up ? wrap_up(v, lo, hi) : wrap_down(v, lo, hi);
    endfunction

    // one up or down action on the field the mode selects
    function automatic fields_t step_fields(fields_t f, logic [3:0] mode, logic up);
        fields_t r;
        r = f;
        case (mode)
            MODE_HOUR:         r.hour = 5'(wrap_step(6'(f.hour), ZERO_MIN, HOUR_MAX, up));
            MODE_MINUTE:       r.minute = wrap_step(f.minute, ZERO_MIN, MINUTE_MAX, up);
            MODE_SECOND:       r.second = wrap_step(f.second, ZERO_MIN, MINUTE_MAX, up);
            MODE_DAY:          r.day = 5'(wrap_step(6'(f.day), DAY_MIN, DAY_MAX, up));
            MODE_MONTH:        r.month = 4'(wrap_step(6'(f.month), MONTH_MIN, MONTH_MAX, up));
            MODE_YEAR:         r.year = up ? f.year + 16'd1 : f.year - 16'd1;
            MODE_ALARM_ON:     r.alarm_on = up;
            MODE_ALARM_HOUR:
                r.alarm_hour = 5'(wrap_step(6'(f.alarm_hour), ZERO_MIN, HOUR_MAX, up));
            MODE_ALARM_MINUTE:
                r.alarm_minute = wrap_step(f.alarm_minute, ZERO_MIN, MINUTE_MAX, up);
            default:           r = f;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/clock_set_buttons_autorepeat.sv =====
// channel   direction  handshake           word
// s_        in         s_valid / s_ready   now_ms, mode/up/down levels, alarm_ringing
// m_        out        m_valid / m_ready   mode, time/date/alarm fields, save/stop pulses
// apb       in         psel/penable/pready hold_delay_ms at 0x0, repeat_interval_ms at 0x4
//
// one word per cycle sustained while m_ready is high: input register, one pass of
// compare/increment logic, result register; m_valid rises with each result register load
// the clock fields and button history update when a word moves into the result register
// a stalled m_ side holds the result; the input register still takes one more word
// aresetn is synchronous, active low, and restores all fields and both delay registers
`timescale 1ns / 1ps
`default_nettype none

module clock_set_buttons_autorepeat import csba_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [31:0]           s_now_ms,
    input  wire logic                  s_mode_level,
    input  wire logic                  s_up_level,
    input  wire logic                  s_down_level,
    input  wire logic                  s_alarm_ringing,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [3:0]                 m_edit_mode,
    output logic [4:0]                 m_hour,
    output logic [5:0]                 m_minute,
    output logic [5:0]                 m_second,
    output logic [4:0]                 m_day,
    output logic [3:0]                 m_month,
    output logic [15:0]                m_year,
    output logic                       m_alarm_on,
    output logic [4:0]                 m_alarm_hour,
    output logic [5:0]                 m_alarm_minute,
    output logic                       m_save_pulse,
    output logic                       m_stop_pulse,

    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic        in_valid_reg;
    logic [31:0] in_now_reg;
    logic [NUM_BUTTONS-1:0] in_level_reg;
    logic        in_ringing_reg;

    logic        out_valid_reg;
    logic [3:0]  out_mode_reg;
    fields_t     out_fields_reg;
    logic        out_save_reg;
    logic        out_stop_reg;

    logic [3:0]  mode_reg;
    fields_t     fields_reg;
    logic [NUM_BUTTONS-1:0] prev_level_reg;
    logic [31:0] hold_start_reg  [NUM_BUTTONS];
    logic [31:0] last_repeat_reg [NUM_BUTTONS];

    logic [15:0] hold_delay_reg;
    logic [15:0] repeat_interval_reg;

    logic        fire;
    logic        in_take;
    logic        cfg_write;
    logic [NUM_BUTTONS-1:0] pressed;
    logic [NUM_BUTTONS-1:0] act;
    logic [31:0] elapsed_hold   [NUM_BUTTONS];
    logic [31:0] elapsed_repeat [NUM_BUTTONS];
    logic [31:0] hold_start_next  [NUM_BUTTONS];
    logic [31:0] last_repeat_next [NUM_BUTTONS];
    logic [3:0]  mode_next;
    fields_t     fields_up;
    fields_t     fields_next;
    logic        save_next;
    logic        stop_next;

    assign fire      = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || fire;
    assign in_take   = s_valid && s_ready;
    assign cfg_write = psel && penable && pwrite;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_REPEAT_INTERVAL) ? {16'd0, repeat_interval_reg}
                                                      : {16'd0, hold_delay_reg};

    always_comb begin
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            elapsed_hold[b]   = in_now_reg - hold_start_reg[b];
            elapsed_repeat[b] = in_now_reg - last_repeat_reg[b];
            pressed[b] = !in_level_reg[b] && prev_level_reg[b];
            act[b] = !in_level_reg[b] && (prev_level_reg[b] ||
                     (elapsed_hold[b] > {16'd0, hold_delay_reg} &&
                      elapsed_repeat[b] > {16'd0, repeat_interval_reg}));
            hold_start_next[b]  = pressed[b] ? in_now_reg : hold_start_reg[b];
            last_repeat_next[b] = act[b] ? in_now_reg : last_repeat_reg[b];
        end

        mode_next = mode_reg;
        if (act[KEY_MODE]) begin
            mode_next = (mode_reg >= MODE_LAST) ? MODE_NORMAL : mode_reg + 4'd1;
        end

        fields_up   = act[KEY_UP] ? step_fields(fields_reg, mode_next, 1'b1) : fields_reg;
        fields_next = act[KEY_DOWN] ? step_fields(fields_up, mode_next, 1'b0) : fields_up;

        save_next = (act[KEY_UP] || act[KEY_DOWN]) && (mode_next inside {[MODE_HOUR:MODE_YEAR]});
        stop_next = in_ringing_reg && (|pressed);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            mode_reg            <= MODE_NORMAL;
            fields_reg          <= FIELDS_RESET;
            prev_level_reg      <= '1;
            hold_delay_reg      <= HOLD_DELAY_RESET;
            repeat_interval_reg <= REPEAT_INTERVAL_RESET;
            for (int b = 0; b < NUM_BUTTONS; b++) begin
                hold_start_reg[b]  <= 32'd0;
                last_repeat_reg[b] <= 32'd0;
            end
        end else begin
            if (in_take) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end

            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end

            if (fire) begin
                mode_reg       <= mode_next;
                fields_reg     <= fields_next;
                prev_level_reg <= in_level_reg;
                for (int b = 0; b < NUM_BUTTONS; b++) begin
                    hold_start_reg[b]  <= hold_start_next[b];
                    last_repeat_reg[b] <= last_repeat_next[b];
                end
            end

            if (cfg_write) begin
                case (paddr[2])
                    REG_HOLD_DELAY:      hold_delay_reg <= pwdata[15:0];
                    REG_REPEAT_INTERVAL: repeat_interval_reg <= pwdata[15:0];
                    default:             hold_delay_reg <= hold_delay_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_now_reg     <= s_now_ms;
            in_level_reg   <= {s_down_level, s_up_level, s_mode_level};
            in_ringing_reg <= s_alarm_ringing;
        end
        if (fire) begin
            out_mode_reg   <= mode_next;
            out_fields_reg <= fields_next;
            out_save_reg   <= save_next;
            out_stop_reg   <= stop_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_edit_mode    = out_mode_reg;
    assign m_hour         = out_fields_reg.hour;
    assign m_minute       = out_fields_reg.minute;
    assign m_second       = out_fields_reg.second;
    assign m_day          = out_fields_reg.day;
    assign m_month        = out_fields_reg.month;
    assign m_year         = out_fields_reg.year;
    assign m_alarm_on     = out_fields_reg.alarm_on;
    assign m_alarm_hour   = out_fields_reg.alarm_hour;
    assign m_alarm_minute = out_fields_reg.alarm_minute;
    assign m_save_pulse   = out_save_reg;
    assign m_stop_pulse   = out_stop_reg;

endmodule

`default_nettype wire

// ===== src/csba_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module csba_checker import csba_pkg::*; (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [3:0]  m_edit_mode,
    input wire logic [4:0]  m_hour,
    input wire logic [5:0]  m_minute,
    input wire logic [5:0]  m_second,
    input wire logic [4:0]  m_day,
    input wire logic [3:0]  m_month,
    input wire logic [4:0]  m_alarm_hour,
    input wire logic [5:0]  m_alarm_minute,
    input wire logic        m_save_pulse,
    input wire logic        pready
);

    // fields always stay inside their wrap ranges
    a_field_ranges: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_edit_mode <= MODE_LAST && 6'(m_hour) <= HOUR_MAX &&
                     m_minute <= MINUTE_MAX && m_second <= MINUTE_MAX &&
                     6'(m_day) >= DAY_MIN && 6'(m_day) <= DAY_MAX &&
                     6'(m_month) >= MONTH_MIN && 6'(m_month) <= MONTH_MAX &&
                     6'(m_alarm_hour) <= HOUR_MAX && m_alarm_minute <= MINUTE_MAX))
        else $error("result field out of range");

    // save only for time/date modes
    a_save_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_save_pulse) |-> (m_edit_mode >= MODE_HOUR && m_edit_mode <= MODE_YEAR))
        else $error("save pulse outside time/date modes");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_edit_mode) && $stable(m_hour) &&
                                   $stable(m_minute) && $stable(m_save_pulse)))
        else $error("result word changed while stalled");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready low");

endmodule

bind clock_set_buttons_autorepeat csba_checker u_csba_checker (.*);

`default_nettype wire
